@@ hw/rtl/bcgd_pkg.sv @@
`default_nettype none
package bcgd_pkg;

  typedef enum logic [2:0] {
    ACT_PRESSED  = 3'd0,
    ACT_RELEASED = 3'd1,
    ACT_CLICK    = 3'd2,
    ACT_DCLICK   = 3'd3,
    ACT_LONG     = 3'd4,
    ACT_IDLE     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  localparam logic [2:0] REG_BUTTON_COUNT = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [2:0] REG_DCLICK_MASK  = 3'd2;
  localparam logic [2:0] REG_REPEAT_MASK  = 3'd3;
  localparam logic [2:0] REG_ACTIVE_HIGH  = 3'd4;

  localparam logic [31:0] JITTER_MS       = 32'd5;
  localparam logic [31:0] DCLICK_MS       = 32'd500;
  localparam logic [31:0] OTHER_WINDOW_MS = 32'd300;
  localparam logic [6:0]  EXTRA_JITTER    = 7'd100;
  localparam int unsigned REPEAT_MS       = 1000;
  localparam int unsigned LONG_EXTRA_MS   = 1000;
  localparam int unsigned MAX_EVENTS      = 4;

endpackage
`default_nettype wire

@@ hw/rtl/button_click_gesture_detector_top.sv @@
`default_nettype none
// button gesture detector: one request on the in_ channel is one scan tick
// carrying edge interrupts and raw pin levels for up to four buttons.
// each tick yields zero or more event requests on the out_ channel (button
// index and action), the final one of a tick flagged with out_last.
// a tick on which no countdown of a button in use runs yields nothing.
// otherwise the idle state applies edges and advances time, and the single
// shared per-button update unit that the scan sequencer walks handles one
// button in use per cycle while at most one event waits; each event then
// moves out through the output register and the flush state closes the tick.
// an event is held in a small queue until the next event or the end of the
// tick shows whether it is the last one.
// the next tick is taken once the previous tick's events have all gone.
// a stalled receiver holds out_valid and its payload; with two events queued
// the scan waits on it. reset clears time, timestamps, counters, flags and
// records and loads long_press_ms with 3000 ms; configuration writes take
// effect at once; the user makes them only while the block is idle, unenforced.
module button_click_gesture_detector_top #(
  parameter int NUM_BUTTONS = 4,
  parameter int TICK_MS     = 10
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [3:0] in_edge_mask,
  input  wire  [3:0] in_level_mask,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [1:0] out_button_index,
  output logic [2:0] out_action,
  output logic       out_last,
  input  wire        cfg_we,
  input  wire  [2:0] cfg_index,
  input  wire [15:0] cfg_data
);

  localparam int NB = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;
  localparam int IW = (NB > 1) ? $clog2(NB) : 1;
  localparam logic [15:0] REPEAT_TICKS = 16'(bcgd_pkg::REPEAT_MS / TICK_MS);
  localparam logic [15:0] DCLICK_TICKS = 16'(bcgd_pkg::DCLICK_MS / TICK_MS);
  localparam int RSH = 17 + $clog2(TICK_MS);
  localparam longint RECIP_L =
    ((longint'(1) << RSH) + longint'(TICK_MS) - longint'(1)) / longint'(TICK_MS);
  localparam logic [18:0] RECIP = 19'(RECIP_L);

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] stamp;
    logic [31:0] dur;
  } rec_t;

  logic [2:0]  button_count_r;
  logic [15:0] long_press_ms_r;
  logic [3:0]  dclick_mask_r, repeat_mask_r, active_high_r;

  logic [31:0] time_ms_r, time_ms_nxt;
  logic [31:0] other_click_r, other_click_nxt;
  logic [6:0]  extra_jitter_r, extra_jitter_nxt;
  logic [15:0] countdown_r [NB], countdown_nxt [NB];
  logic [31:0] press_time_r [NB], press_time_nxt [NB];
  logic [15:0] repeat_cnt_r [NB], repeat_cnt_nxt [NB];
  rec_t        new_rec_r [NB], new_rec_nxt [NB];
  rec_t        old_rec_r [NB], old_rec_nxt [NB];
  logic [NB-1:0] pressed_r, pressed_nxt, started_r, started_nxt;
  logic [NB-1:0] long_r, long_nxt, valid_r, valid_nxt, dwait_r, dwait_nxt;

  bcgd_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [3:0]    level_r, level_nxt;

  // event queue of a tick: during the scan an event leaves only once a later one is queued
  logic [1:0] q_idx_r [3], q_idx_nxt [3];
  logic [2:0] q_act_r [3], q_act_nxt [3];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0] out_idx_r, out_idx_nxt;
  logic [2:0] out_act_r, out_act_nxt;

  logic [2:0]  cnt;
  logic [15:0] long_reload;
  logic [16:0] reload_sum;
  logic [35:0] reload_prod;

  assign cnt = (button_count_r > 3'(NB)) ? 3'(NB) : button_count_r;
  assign reload_sum = {1'b0, long_press_ms_r} + 17'(bcgd_pkg::LONG_EXTRA_MS);
  // divide by the tick length through a reciprocal multiply, exact for 17 bits
  assign reload_prod = 36'(reload_sum) * 36'(RECIP);
  always_comb begin
    logic [16:0] q;
    q = 17'(reload_prod >> RSH);
    long_reload = q[16] ? 16'hffff : q[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_count_r  <= '0;
      long_press_ms_r <= 16'd3000;
      dclick_mask_r   <= '0;
      repeat_mask_r   <= '0;
      active_high_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcgd_pkg::REG_BUTTON_COUNT: button_count_r  <= cfg_data[2:0];
        bcgd_pkg::REG_LONG_PRESS:   long_press_ms_r <= cfg_data;
        bcgd_pkg::REG_DCLICK_MASK:  dclick_mask_r   <= cfg_data[3:0];
        bcgd_pkg::REG_REPEAT_MASK:  repeat_mask_r   <= cfg_data[3:0];
        bcgd_pkg::REG_ACTIVE_HIGH:  active_high_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready         = (state_r == bcgd_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_button_index = out_idx_r;
  assign out_action       = out_act_r;
  assign out_last         = out_last_r;

  always_comb begin
    logic        going;
    logic        rep, now_pressed, skip, emit_ok;
    logic [31:0] slot, det;
    logic [IW-1:0] i;
    logic [15:0] c;
    logic [1:0]  e_idx [2];
    logic [2:0]  e_act [2];
    logic [1:0]  ne;
    logic        step_go, out_free;

    time_ms_nxt = time_ms_r;
    other_click_nxt = other_click_r;
    extra_jitter_nxt = extra_jitter_r;
    countdown_nxt = countdown_r;
    press_time_nxt = press_time_r;
    repeat_cnt_nxt = repeat_cnt_r;
    new_rec_nxt = new_rec_r;
    old_rec_nxt = old_rec_r;
    pressed_nxt = pressed_r;
    started_nxt = started_r;
    long_nxt = long_r;
    valid_nxt = valid_r;
    dwait_nxt = dwait_r;
    state_nxt = state_r;
    idx_nxt = idx_r;
    level_nxt = level_r;
    q_idx_nxt = q_idx_r;
    q_act_nxt = q_act_r;
    q_cnt_nxt = q_cnt_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt = out_last_r;
    out_idx_nxt = out_idx_r;
    out_act_nxt = out_act_r;
    going = 1'b0;
    rep = 1'b0;
    now_pressed = 1'b0;
    skip = 1'b0;
    slot = '0;
    det = '0;
    i = idx_r;
    c = '0;
    e_idx[0] = '0; e_idx[1] = '0;
    e_act[0] = '0; e_act[1] = '0;
    ne = '0;
    step_go = 1'b0;
    emit_ok = 1'b0;

    out_free = !out_valid_r || out_ready;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      bcgd_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          for (int k = 0; k < NB; k++) begin
            if (3'(k) < cnt && in_edge_mask[k]) begin
              pressed_nxt[k] = 1'b1;
              press_time_nxt[k] = time_ms_r;
              repeat_cnt_nxt[k] = '0;
              countdown_nxt[k] = long_reload;
            end
          end
          for (int k = 0; k < NB; k++)
            if (3'(k) < cnt && (countdown_nxt[k] != 0)) going = 1'b1;
          time_ms_nxt = time_ms_r + 32'(TICK_MS);
          level_nxt = in_level_mask;
          idx_nxt = '0;
          q_cnt_nxt = '0;
          if (!going) begin
            started_nxt = '0;
            long_nxt = '0;
            dwait_nxt = '0;
            for (int k = 0; k < NB; k++) repeat_cnt_nxt[k] = '0;
          end else begin
            state_nxt = bcgd_pkg::ST_SCAN;
          end
        end
      end

      bcgd_pkg::ST_SCAN: begin
        // a step runs while at most one event waits, so it can never be the last
        step_go = (q_cnt_r <= 2'd1);
        if (q_cnt_r >= 2'd2 && out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt = q_idx_r[0];
          out_act_nxt = q_act_r[0];
          out_last_nxt = 1'b0;
          q_idx_nxt[0] = q_idx_r[1];
          q_act_nxt[0] = q_act_r[1];
          q_idx_nxt[1] = q_idx_r[2];
          q_act_nxt[1] = q_act_r[2];
          q_cnt_nxt = q_cnt_r - 2'd1;
        end
        if (step_go) begin
          rep = repeat_mask_r[i];
          if (countdown_r[i] != 0) begin
            if (pressed_r[i] || dwait_r[i])
              countdown_nxt[i] = countdown_r[i] - 16'd1;
            if (countdown_nxt[i] != 0 && pressed_r[i]) begin
              now_pressed = active_high_r[i] ? level_r[i] : !level_r[i];
              if (!started_r[i] && now_pressed) begin
                started_nxt[i] = 1'b1;
                e_idx[ne[0]] = 2'(i); e_act[ne[0]] = bcgd_pkg::ACT_PRESSED;
                ne = ne + 2'd1;
                skip = 1'b1;
              end else begin
                slot = time_ms_r - press_time_r[i];
                if (now_pressed) begin
                  if (slot >= {16'd0, long_press_ms_r} && !long_r[i]) begin
                    old_rec_nxt[i] = new_rec_r[i];
                    new_rec_nxt[i].action = bcgd_pkg::ACT_LONG;
                    new_rec_nxt[i].stamp = time_ms_r;
                    new_rec_nxt[i].dur = slot;
                    valid_nxt[i] = 1'b1;
                    countdown_nxt[i] = '0;
                    long_nxt[i] = 1'b1;
                  end else if (long_r[i] && rep) begin
                    countdown_nxt[i] = long_reload;
                  end
                  if (rep) begin
                    c = repeat_cnt_r[i];
                    repeat_cnt_nxt[i] = c + 16'd1;
                    if (c >= REPEAT_TICKS) begin
                      repeat_cnt_nxt[i] = '0;
                      e_idx[ne[0]] = 2'(i); e_act[ne[0]] = bcgd_pkg::ACT_PRESSED;
                      ne = ne + 2'd1;
                    end
                  end
                  if ((time_ms_r - other_click_r) < bcgd_pkg::OTHER_WINDOW_MS &&
                      cnt > 3'd1 && i == '0)
                    extra_jitter_nxt = bcgd_pkg::EXTRA_JITTER;
                  else
                    extra_jitter_nxt = '0;
                end else begin
                  if (slot > bcgd_pkg::JITTER_MS + {25'd0, extra_jitter_r}) begin
                    old_rec_nxt[i] = new_rec_r[i];
                    new_rec_nxt[i].stamp = time_ms_r;
                    new_rec_nxt[i].dur = slot;
                    countdown_nxt[i] = '0;
                    if (slot < {16'd0, long_press_ms_r} && !long_r[i]) begin
                      det = time_ms_r - new_rec_r[i].stamp;
                      if (dclick_mask_r[i]) begin
                        if (det < bcgd_pkg::DCLICK_MS && slot < bcgd_pkg::DCLICK_MS &&
                            new_rec_r[i].action == bcgd_pkg::ACT_CLICK &&
                            new_rec_r[i].dur < bcgd_pkg::DCLICK_MS) begin
                          old_rec_nxt[i].action = bcgd_pkg::ACT_IDLE;
                          new_rec_nxt[i].action = bcgd_pkg::ACT_DCLICK;
                          valid_nxt[i] = 1'b1;
                          dwait_nxt[i] = 1'b0;
                        end else if (!dwait_r[i]) begin
                          new_rec_nxt[i].action = bcgd_pkg::ACT_CLICK;
                          valid_nxt[i] = 1'b1;
                          dwait_nxt[i] = 1'b1;
                          countdown_nxt[i] = DCLICK_TICKS;
                        end
                      end else begin
                        new_rec_nxt[i].action = bcgd_pkg::ACT_CLICK;
                        valid_nxt[i] = 1'b1;
                        dwait_nxt[i] = 1'b1;
                      end
                    end else begin
                      valid_nxt[i] = 1'b0;
                    end
                  end
                  if (started_r[i]) begin
                    e_idx[ne[0]] = 2'(i); e_act[ne[0]] = bcgd_pkg::ACT_RELEASED;
                    ne = ne + 2'd1;
                    long_nxt[i] = 1'b0;
                  end
                end
                pressed_nxt[i] = now_pressed;
              end
            end
            if (!skip && countdown_nxt[i] == 0) begin
              emit_ok = valid_nxt[i] && started_nxt[i];
              if (emit_ok) begin
                e_idx[ne[0]] = 2'(i); e_act[ne[0]] = new_rec_nxt[i].action;
                ne = ne + 2'd1;
                if (!long_nxt[i]) started_nxt[i] = 1'b0;
                valid_nxt[i] = 1'b0;
                if (new_rec_nxt[i].action == bcgd_pkg::ACT_CLICK && cnt > 3'd1 &&
                    i != '0)
                  other_click_nxt = time_ms_r;
              end
              if (long_nxt[i] && rep) begin
                countdown_nxt[i] = long_reload;
                valid_nxt[i] = 1'b0;
              end else if (long_nxt[i]) begin
                started_nxt[i] = 1'b0;
                long_nxt[i] = 1'b0;
                repeat_cnt_nxt[i] = '0;
              end
            end
          end
          // new events go behind the one still waiting, if any
          if (q_cnt_r == 2'd0) begin
            q_idx_nxt[0] = e_idx[0]; q_act_nxt[0] = e_act[0];
            q_idx_nxt[1] = e_idx[1]; q_act_nxt[1] = e_act[1];
          end else begin
            q_idx_nxt[1] = e_idx[0]; q_act_nxt[1] = e_act[0];
            q_idx_nxt[2] = e_idx[1]; q_act_nxt[2] = e_act[1];
          end
          q_cnt_nxt = q_cnt_r + ne;
          if ((3'(idx_r) + 3'd1) >= cnt) state_nxt = bcgd_pkg::ST_FLUSH;
          else idx_nxt = idx_r + IW'(1);
        end
      end

      bcgd_pkg::ST_FLUSH: begin
        // the last queued event of the tick carries the last flag
        if (q_cnt_r != 2'd0 && out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt = q_idx_r[0];
          out_act_nxt = q_act_r[0];
          out_last_nxt = (q_cnt_r == 2'd1);
          q_idx_nxt[0] = q_idx_r[1];
          q_act_nxt[0] = q_act_r[1];
          q_idx_nxt[1] = q_idx_r[2];
          q_act_nxt[1] = q_act_r[2];
          q_cnt_nxt = q_cnt_r - 2'd1;
        end
        if (q_cnt_r == 2'd0) state_nxt = bcgd_pkg::ST_IDLE;
      end

      default: state_nxt = bcgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcgd_pkg::ST_IDLE;
      idx_r <= '0;
      time_ms_r <= '0;
      other_click_r <= '0;
      extra_jitter_r <= '0;
      pressed_r <= '0;
      started_r <= '0;
      long_r <= '0;
      valid_r <= '0;
      dwait_r <= '0;
      q_cnt_r <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
      for (int k = 0; k < NB; k++) begin
        countdown_r[k] <= '0;
        press_time_r[k] <= '0;
        repeat_cnt_r[k] <= '0;
        new_rec_r[k] <= '{action: bcgd_pkg::ACT_IDLE, stamp: '0, dur: '0};
        old_rec_r[k] <= '{action: bcgd_pkg::ACT_IDLE, stamp: '0, dur: '0};
      end
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      time_ms_r <= time_ms_nxt;
      other_click_r <= other_click_nxt;
      extra_jitter_r <= extra_jitter_nxt;
      pressed_r <= pressed_nxt;
      started_r <= started_nxt;
      long_r <= long_nxt;
      valid_r <= valid_nxt;
      dwait_r <= dwait_nxt;
      q_cnt_r <= q_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r <= out_last_nxt;
      countdown_r <= countdown_nxt;
      press_time_r <= press_time_nxt;
      repeat_cnt_r <= repeat_cnt_nxt;
      new_rec_r <= new_rec_nxt;
      old_rec_r <= old_rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    q_idx_r <= q_idx_nxt;
    q_act_r <= q_act_nxt;
    out_idx_r <= out_idx_nxt;
    out_act_r <= out_act_nxt;
  end

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bcgd_pkg::ST_IDLE) |-> !in_ready)
    else $error("tick taken while scanning");
  a_held_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_act_r)))
    else $error("output request dropped under stall");
  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_act_r != bcgd_pkg::ACT_IDLE))
    else $error("idle action emitted");

endmodule
`default_nettype wire

@@ tb/sv/button_click_gesture_detector_top_tb.sv @@
`timescale 1ns / 1ps
module button_click_gesture_detector_top_tb;

  localparam int NB = 4;
  localparam int TICK = 10;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [1:0]         button;
    bcgd_pkg::action_t  action;
    logic               last;
  } gesture_event_t;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] stamp;
    logic [31:0] dur;
  } gesture_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_edge_mask;
  logic [3:0]  in_level_mask;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_button_index;
  logic [2:0]  out_action;
  logic        out_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  button_click_gesture_detector_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_edge_mask(in_edge_mask), .in_level_mask(in_level_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_button_index(out_button_index), .out_action(out_action), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of configuration and state
  logic [2:0]  m_count;
  logic [15:0] m_long_ms;
  logic [3:0]  m_dclick_en, m_repeat_en, m_active_hi;
  logic [31:0] m_now_ms, m_other_click;
  logic [6:0]  m_extra_jitter;
  logic [15:0] m_countdown [NB];
  logic [31:0] m_press_at [NB];
  logic [15:0] m_repeat [NB];
  gesture_rec_t m_new_rec [NB];
  gesture_rec_t m_old_rec [NB];
  bit m_pressed [NB], m_started [NB], m_long_held [NB], m_valid [NB], m_dwait [NB];

  gesture_event_t expected_events[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned send_idle_pct, recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [15:0] long_reload();
    logic [31:0] v;
    v = ({16'd0, m_long_ms} + bcgd_pkg::LONG_EXTRA_MS) / TICK;
    return (v > 32'd65535) ? 16'hffff : v[15:0];
  endfunction

  task automatic gesture_reset();
    m_count = 0; m_long_ms = 16'd3000;
    m_dclick_en = 0; m_repeat_en = 0; m_active_hi = 0;
    m_now_ms = 0; m_other_click = 0; m_extra_jitter = 0;
    for (int i = 0; i < NB; i++) begin
      m_countdown[i] = 0; m_press_at[i] = 0; m_repeat[i] = 0;
      m_new_rec[i] = '{bcgd_pkg::ACT_IDLE, 32'd0, 32'd0};
      m_old_rec[i] = m_new_rec[i];
      m_pressed[i] = 0; m_started[i] = 0; m_long_held[i] = 0;
      m_valid[i] = 0; m_dwait[i] = 0;
    end
  endtask

  task automatic push_event(input int b, input logic [2:0] act, ref int n);
    gesture_event_t e;
    e.button = b[1:0];
    e.action = bcgd_pkg::action_t'(act);
    e.last = 1'b0;
    expected_events.push_back(e);
    n++;
  endtask

  task automatic predict_tick(input logic [3:0] edges, input logic [3:0] levels);
    int cnt, n;
    bit going, rep, hi, now_pr;
    logic [31:0] slot, det;
    logic [15:0] c;
    gesture_event_t e;
    cnt = (m_count > 4) ? 4 : m_count;
    n = 0;
    going = 0;
    for (int i = 0; i < cnt; i++)
      if (edges[i]) begin
        m_pressed[i] = 1; m_press_at[i] = m_now_ms;
        m_repeat[i] = 0; m_countdown[i] = long_reload();
      end
    m_now_ms = m_now_ms + TICK;
    for (int i = 0; i < cnt; i++) if (m_countdown[i] != 0) going = 1;
    if (!going) begin
      for (int i = 0; i < NB; i++) begin
        m_started[i] = 0; m_long_held[i] = 0; m_repeat[i] = 0; m_dwait[i] = 0;
      end
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      rep = m_repeat_en[i];
      if (m_countdown[i] == 0) continue;
      if (m_pressed[i] || m_dwait[i]) m_countdown[i]--;
      if (m_countdown[i] != 0 && m_pressed[i]) begin
        hi = m_active_hi[i];
        now_pr = hi ? levels[i] : !levels[i];
        if (!m_started[i] && now_pr) begin
          m_started[i] = 1;
          push_event(i, bcgd_pkg::ACT_PRESSED, n);
          continue;
        end
        slot = m_now_ms - m_press_at[i];
        if (now_pr) begin
          if (slot >= {16'd0, m_long_ms} && !m_long_held[i]) begin
            m_old_rec[i] = m_new_rec[i];
            m_new_rec[i] = '{bcgd_pkg::ACT_LONG, m_now_ms, slot};
            m_valid[i] = 1; m_countdown[i] = 0; m_long_held[i] = 1;
          end else if (m_long_held[i] && rep) begin
            m_countdown[i] = long_reload();
          end
          if (rep) begin
            c = m_repeat[i];
            m_repeat[i] = c + 16'd1;
            if (c >= bcgd_pkg::REPEAT_MS / TICK) begin
              m_repeat[i] = 0;
              push_event(i, bcgd_pkg::ACT_PRESSED, n);
            end
          end
          if ((m_now_ms - m_other_click) < bcgd_pkg::OTHER_WINDOW_MS && cnt > 1 && i == 0)
            m_extra_jitter = bcgd_pkg::EXTRA_JITTER;
          else
            m_extra_jitter = 0;
        end else begin
          if (slot > bcgd_pkg::JITTER_MS + {25'd0, m_extra_jitter}) begin
            m_old_rec[i] = m_new_rec[i];
            m_new_rec[i].stamp = m_now_ms;
            m_new_rec[i].dur = slot;
            m_countdown[i] = 0;
            if (slot < {16'd0, m_long_ms} && !m_long_held[i]) begin
              det = m_new_rec[i].stamp - m_old_rec[i].stamp;
              if (m_dclick_en[i]) begin
                if (det < bcgd_pkg::DCLICK_MS && m_new_rec[i].dur < bcgd_pkg::DCLICK_MS &&
                    m_old_rec[i].action == bcgd_pkg::ACT_CLICK &&
                    m_old_rec[i].dur < bcgd_pkg::DCLICK_MS) begin
                  m_old_rec[i].action = bcgd_pkg::ACT_IDLE;
                  m_new_rec[i].action = bcgd_pkg::ACT_DCLICK;
                  m_valid[i] = 1; m_countdown[i] = 0; m_dwait[i] = 0;
                end else if (!m_dwait[i]) begin
                  m_new_rec[i].action = bcgd_pkg::ACT_CLICK;
                  m_valid[i] = 1; m_dwait[i] = 1;
                  m_countdown[i] = 16'(bcgd_pkg::DCLICK_MS / TICK);
                end
              end else begin
                m_new_rec[i].action = bcgd_pkg::ACT_CLICK;
                m_valid[i] = 1; m_countdown[i] = 0; m_dwait[i] = 1;
              end
            end else begin
              m_valid[i] = 0; m_countdown[i] = 0;
            end
          end
          if (m_started[i]) begin
            push_event(i, bcgd_pkg::ACT_RELEASED, n);
            m_long_held[i] = 0;
          end
        end
        m_pressed[i] = now_pr;
      end
      if (m_countdown[i] == 0) begin
        if (m_valid[i] && m_started[i]) begin
          push_event(i, m_new_rec[i].action, n);
          if (!m_long_held[i]) m_started[i] = 0;
          m_valid[i] = 0;
          if (m_new_rec[i].action == bcgd_pkg::ACT_CLICK && cnt > 1 && i != 0)
            m_other_click = m_now_ms;
        end
        if (m_long_held[i] && rep) begin
          m_countdown[i] = long_reload();
          m_valid[i] = 0;
        end else if (m_long_held[i]) begin
          m_started[i] = 0; m_long_held[i] = 0; m_repeat[i] = 0;
        end
      end
    end
    if (n > 0) begin
      e = expected_events.pop_back();
      e.last = 1'b1;
      expected_events.push_back(e);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    gesture_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event b%0d a%0d", out_button_index, out_action));
      end else begin
        want = expected_events.pop_front();
        if (out_button_index !== want.button)
          report_mismatch($sformatf("button got %0d want %0d", out_button_index, want.button));
        if (out_action !== want.action)
          report_mismatch($sformatf("action got %0d want %0d", out_action, want.action));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // in_valid stays up after a request when the next one follows at once
  task automatic send_tick(input logic [3:0] edges, input logic [3:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_mask <= edges;
    in_level_mask <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(edges, levels);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      bcgd_pkg::REG_BUTTON_COUNT: m_count = val[2:0];
      bcgd_pkg::REG_LONG_PRESS:   m_long_ms = val;
      bcgd_pkg::REG_DCLICK_MASK:  m_dclick_en = val[3:0];
      bcgd_pkg::REG_REPEAT_MASK:  m_repeat_en = val[3:0];
      bcgd_pkg::REG_ACTIVE_HIGH:  m_active_hi = val[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [2:0] cnt, input logic [15:0] lp,
                           input logic [3:0] dc, input logic [3:0] rp, input logic [3:0] ah);
    drain();
    write_reg(bcgd_pkg::REG_BUTTON_COUNT, {13'd0, cnt});
    write_reg(bcgd_pkg::REG_LONG_PRESS, lp);
    write_reg(bcgd_pkg::REG_DCLICK_MASK, {12'd0, dc});
    write_reg(bcgd_pkg::REG_REPEAT_MASK, {12'd0, rp});
    write_reg(bcgd_pkg::REG_ACTIVE_HIGH, {12'd0, ah});
    cfg_we <= 1'b0;
  endtask

  // press button b for hold ticks then release, levels follow polarity
  task automatic press_release(input int b, input int hold, input bit noise);
    logic [3:0] up, lv;
    up = m_active_hi;
    send_tick(4'b1 << b, up ^ (4'b1 << b));
    for (int t = 0; t < hold; t++) begin
      lv = up ^ (4'b1 << b);
      if (noise) lv = lv ^ ($urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'd0);
      send_tick(noise && $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'd0, lv);
    end
    send_tick(4'd0, up);
  endtask

  task automatic test_directed();
    configure(3'd4, 16'd100, 4'b1111, 4'b0000, 4'b0000);
    send_tick(4'hf, 4'h0);
    send_tick(4'h0, 4'hf);
    send_tick(4'h0, 4'h0);
    press_release(0, 3, 0);
    press_release(0, 3, 0);
    repeat (3) send_tick(4'h0, 4'hf);
    press_release(1, 20, 0);
    press_release(2, 2, 0);
    press_release(0, 2, 0);
    configure(3'd7, 16'd0, 4'b0000, 4'b1111, 4'b1111);
    press_release(3, 5, 0);
    configure(3'd1, 16'hffff, 4'b0101, 4'b0000, 4'b1010);
    send_tick(4'hf, 4'hf);
    send_tick(4'h0, 4'h0);
    configure(3'd0, 16'd3000, 4'd0, 4'd0, 4'd0);
    send_tick(4'hf, 4'h5);
  endtask

  task automatic test_gestures(input int items);
    int sent, b, hold;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(5))
        0, 1: begin
          b = $urandom_range(m_count > 4 ? 3 : (m_count == 0 ? 0 : m_count - 1));
          hold = $urandom_range(1, 6);
          press_release(b, hold, 0);
          sent += hold + 2;
        end
        2: begin
          b = $urandom_range(3);
          hold = $urandom_range(5, 40);
          press_release(b, hold, 1);
          sent += hold + 2;
        end
        3: begin
          // pause until every event has drained, then resume
          in_valid <= 1'b0;
          while (expected_events.size() != 0) @(posedge clk);
          send_tick(4'($urandom_range(15)), 4'($urandom_range(15)));
          sent++;
        end
        default: begin
          send_tick(4'($urandom_range(15)), 4'($urandom_range(15)));
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_settings();
    configure(3'd4, 16'd150, 4'b1111, 4'b0011, 4'b0101);
    test_gestures(36);
    configure(3'd2, 16'd250, 4'b0001, 4'b1111, 4'b0000);
    test_gestures(34);
    configure(3'($urandom_range(7)), 16'($urandom_range(400)),
              4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
    test_gestures(34);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_edge_mask = 4'd0; in_level_mask = 4'd0;
    out_ready = 1'b0;
    cfg_we = 1'b0; cfg_index = bcgd_pkg::REG_BUTTON_COUNT; cfg_data = 16'd0;
    errors = 0; cycles = 0;
    send_idle_pct = 12; recv_idle_pct = 64;
    gesture_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    send_idle_pct = 64; recv_idle_pct = 12;
    test_settings();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_settings();
    drain();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bcgd_pkg.sv
hw/rtl/button_click_gesture_detector_top.sv
tb/sv/button_click_gesture_detector_top_tb.sv
